FILE: rtl/ipfd_pkg.sv
// ----------------------------------------------------------------------------
// ipfd_pkg
// Shared types, codes and defaults of the IPv4 forwarding decision block.
// ----------------------------------------------------------------------------
package ipfd_pkg;

  localparam int ROUTE_ENTRIES_DEF    = 16;
  localparam int NEIGHBOR_ENTRIES_DEF = 16;
  localparam int PORTS_DEF            = 4;

  localparam logic [1:0] OP_ROUTE = 2'd0;
  localparam logic [1:0] OP_ARP   = 2'd1;
  localparam logic [1:0] OP_PMAC  = 2'd2;
  localparam logic [1:0] OP_BYTE  = 2'd3;

  localparam logic [2:0] V_FWD     = 3'd0;
  localparam logic [2:0] V_SHORT   = 3'd1;
  localparam logic [2:0] V_BADHDR  = 3'd2;
  localparam logic [2:0] V_CSUM    = 3'd3;
  localparam logic [2:0] V_TTL     = 3'd4;
  localparam logic [2:0] V_NOROUTE = 3'd5;
  localparam logic [2:0] V_NOARP   = 3'd6;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] route_prefix;
    logic [31:0] route_mask;
    logic [31:0] next_hop_addr;
    logic [1:0]  out_port;
    logic [47:0] hw_addr;
    logic [7:0]  frame_byte;
    logic        frame_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [1:0]  egress_port;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } out_item_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, v};
    t = {1'b0, t[15:0]} + {16'd0, t[16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

FILE: rtl/ipfd_if.sv
// ----------------------------------------------------------------------------
// ipfd_in_if / ipfd_out_if
// Valid/ready channels carrying input items and verdicts.
// ----------------------------------------------------------------------------
interface ipfd_in_if;
  logic               valid;
  logic               ready;
  ipfd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ipfd_out_if;
  logic                valid;
  logic                ready;
  ipfd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ipv4_forwarding_decision.sv
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision
// Table writes and frame bytes in, one verdict per frame out.
// ----------------------------------------------------------------------------
// Usage: all items arrive on in_ch. Ops 0..2 write the route, ARP and port
// MAC tables. Op 3 carries one frame byte; header fields and a running ones'
// complement sum are captured as bytes stream in, one a cycle when ready.
// On the byte with frame_last set, in_ch drops ready and a sequencer walks
// the route table with one shared masked compare (one entry a cycle), then
// the ARP table with the same compare unit, then writes the verdict into
// the output register.
// The walk stops early on an ARP hit and is skipped on header drops.
// A verdict waits in the output register while out_ch is stalled; table
// writes and bytes of the next frame are still taken during that wait, and
// only the next last byte waits for the register to empty.
// Reset (rst, synchronous) clears the in-use bits, port MACs, frame state
// and the output valid; route and ARP payloads stay undefined until written.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision #(
  parameter int ROUTE_ENTRIES    = ipfd_pkg::ROUTE_ENTRIES_DEF,
  parameter int NEIGHBOR_ENTRIES = ipfd_pkg::NEIGHBOR_ENTRIES_DEF,
  parameter int PORTS            = ipfd_pkg::PORTS_DEF
) (
  input logic        clk,
  input logic        rst,
  ipfd_in_if.sink    in_ch,
  ipfd_out_if.source out_ch
);

  localparam int RW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int NW = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUTE = 3'd1;
  localparam logic [2:0] S_GW    = 3'd2;
  localparam logic [2:0] S_ARP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  ipfd_pkg::in_item_t d;
  assign d = in_ch.data;

  logic [31:0] rt_prefix [ROUTE_ENTRIES];
  logic [31:0] rt_mask   [ROUTE_ENTRIES];
  logic [31:0] rt_gw     [ROUTE_ENTRIES];
  logic [1:0]  rt_port   [ROUTE_ENTRIES];
  logic [ROUTE_ENTRIES-1:0] rt_use;
  logic [31:0] nb_addr [NEIGHBOR_ENTRIES];
  logic [47:0] nb_mac  [NEIGHBOR_ENTRIES];
  logic [NEIGHBOR_ENTRIES-1:0] nb_use;
  logic [47:0] pmac [PORTS];

  logic [2:0]  state;
  logic [RW:0] ri;
  logic [NW:0] ni;
  logic        found;
  logic [31:0] top_mask;
  logic [RW-1:0] best;
  logic [31:0] gw;
  logic [1:0]  port;
  logic [7:0]  ttl_q;
  logic [15:0] sum_q;
  logic [31:0] dst_q;

  // frame capture
  logic [16:0] byte_count;
  logic [15:0] etype;
  logic [7:0]  vihl;
  logic [15:0] tlen;
  logic [7:0]  ttl;
  logic [15:0] rx_sum;
  logic [31:0] dst;
  logic [15:0] hsum;

  logic out_valid;
  ipfd_pkg::out_item_t out_q;

  // write addresses, sized to each table
  logic [RW-1:0] rt_wi;
  logic [NW-1:0] nb_wi;
  logic [PW-1:0] pm_wi;
  assign rt_wi = RW'(d.entry_index);
  assign nb_wi = NW'(d.entry_index);
  assign pm_wi = PW'(d.entry_index);

  logic take, is_byte, last_beat;
  assign is_byte   = d.op == ipfd_pkg::OP_BYTE;
  assign last_beat = is_byte && d.frame_last;
  assign in_ch.ready = (state == S_IDLE) && !(last_beat && out_valid);
  assign take = in_ch.valid && in_ch.ready;

  // combinational view of the header after this byte
  logic [15:0] etype_n, tlen_n, rx_sum_n, hsum_n;
  logic [7:0]  vihl_n, ttl_n;
  logic [31:0] dst_n;
  logic [16:0] cnt_n, off;
  logic [5:0]  hlen_n;

  always_comb begin
    etype_n = etype; vihl_n = vihl; tlen_n = tlen; ttl_n = ttl;
    rx_sum_n = rx_sum; dst_n = dst; hsum_n = hsum;
    unique case (byte_count)
      17'd12: etype_n[15:8] = d.frame_byte;
      17'd13: etype_n[7:0] = d.frame_byte;
      17'd14: vihl_n = d.frame_byte;
      17'd16: tlen_n[15:8] = d.frame_byte;
      17'd17: tlen_n[7:0] = d.frame_byte;
      17'd22: ttl_n = d.frame_byte;
      17'd24: rx_sum_n[15:8] = d.frame_byte;
      17'd25: rx_sum_n[7:0] = d.frame_byte;
      17'd30: dst_n[31:24] = d.frame_byte;
      17'd31: dst_n[23:16] = d.frame_byte;
      17'd32: dst_n[15:8] = d.frame_byte;
      17'd33: dst_n[7:0] = d.frame_byte;
      default: ;
    endcase
    // IHL including this byte, so the version/IHL byte itself is summed
    hlen_n = {vihl_n[3:0], 2'b00};
    off = byte_count - 17'd14;
    if (byte_count >= 17'd14 && off < {11'd0, hlen_n} && off != 17'd8 &&
        off != 17'd10 && off != 17'd11) begin
      hsum_n = ipfd_pkg::fold_add(hsum, off[0] ? {8'd0, d.frame_byte}
                                               : {d.frame_byte, 8'd0});
    end
    cnt_n = (byte_count < ipfd_pkg::COUNT_MAX) ? byte_count + 17'd1 : byte_count;
  end

  // header checks on the completed frame
  logic [2:0]  hdr_v;
  logic [15:0] calc;
  always_comb begin
    calc = ~ipfd_pkg::fold_add(hsum_n, {ttl_n, 8'd0});
    priority if (cnt_n < 17'd34 || etype_n != ipfd_pkg::ETYPE_IPV4)
      hdr_v = ipfd_pkg::V_SHORT;
    else if (vihl_n[7:4] != 4'd4 || vihl_n[3:0] < 4'd5 ||
             tlen_n < {10'd0, vihl_n[3:0], 2'b00} ||
             {1'b0, tlen_n} > cnt_n - 17'd14)
      hdr_v = ipfd_pkg::V_BADHDR;
    else if (calc != rx_sum_n)
      hdr_v = ipfd_pkg::V_CSUM;
    else if (ttl_n <= 8'd1)
      hdr_v = ipfd_pkg::V_TTL;
    else
      hdr_v = ipfd_pkg::V_FWD;
  end

  // table writes
  always_ff @(posedge clk) begin
    if (take && d.op == ipfd_pkg::OP_ROUTE && {28'd0, d.entry_index} < ROUTE_ENTRIES) begin
      rt_prefix[rt_wi] <= d.route_prefix;
      rt_mask[rt_wi]   <= d.route_mask;
      rt_gw[rt_wi]     <= d.next_hop_addr;
      rt_port[rt_wi]   <= d.out_port;
    end
    if (take && d.op == ipfd_pkg::OP_ARP && {28'd0, d.entry_index} < NEIGHBOR_ENTRIES) begin
      nb_addr[nb_wi] <= d.next_hop_addr;
      nb_mac[nb_wi]  <= d.hw_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_use <= '0;
      nb_use <= '0;
      for (int k = 0; k < PORTS; k++) pmac[k] <= '0;
    end else if (take) begin
      if (d.op == ipfd_pkg::OP_ROUTE && {28'd0, d.entry_index} < ROUTE_ENTRIES)
        rt_use[rt_wi] <= d.entry_valid;
      if (d.op == ipfd_pkg::OP_ARP && {28'd0, d.entry_index} < NEIGHBOR_ENTRIES)
        nb_use[nb_wi] <= d.entry_valid;
      if (d.op == ipfd_pkg::OP_PMAC && {28'd0, d.entry_index} < PORTS)
        pmac[pm_wi] <= d.hw_addr;
    end
  end

  // shared compare unit: route match or neighbor address match
  logic [31:0] cmp_a, cmp_b, cmp_m;
  logic        cmp_eq;
  always_comb begin
    if (state == S_ARP) begin
      cmp_a = nb_addr[ni[NW-1:0]];
      cmp_b = gw;
      cmp_m = '1;
    end else begin
      cmp_a = dst_q;
      cmp_b = rt_prefix[ri[RW-1:0]];
      cmp_m = rt_mask[ri[RW-1:0]];
    end
    cmp_eq = (cmp_a & cmp_m) == (cmp_b & cmp_m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      byte_count <= '0;
      etype <= '0; vihl <= '0; tlen <= '0; ttl <= '0;
      rx_sum <= '0; dst <= '0; hsum <= '0;
      ri <= '0; ni <= '0; found <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take && is_byte) begin
            if (d.frame_last) begin
              byte_count <= '0;
              etype <= '0; vihl <= '0; tlen <= '0; ttl <= '0;
              rx_sum <= '0; dst <= '0; hsum <= '0;
              out_q <= '{verdict: hdr_v, default: '0};
              ttl_q <= ttl_n;
              sum_q <= hsum_n;
              dst_q <= dst_n;
              ri <= '0;
              found <= 1'b0;
              top_mask <= '0;
              best <= '0;
              if (hdr_v == ipfd_pkg::V_FWD) state <= S_ROUTE;
              else out_valid <= 1'b1;
            end else begin
              byte_count <= cnt_n;
              etype <= etype_n; vihl <= vihl_n; tlen <= tlen_n; ttl <= ttl_n;
              rx_sum <= rx_sum_n; dst <= dst_n; hsum <= hsum_n;
            end
          end
        end
        S_ROUTE: begin
          if (rt_use[ri[RW-1:0]] && cmp_eq && rt_mask[ri[RW-1:0]] >= top_mask) begin
            top_mask <= rt_mask[ri[RW-1:0]];
            best <= ri[RW-1:0];
            found <= 1'b1;
          end
          if (ri == (RW+1)'(ROUTE_ENTRIES - 1)) state <= S_GW;
          else ri <= ri + 1'b1;
        end
        S_GW: begin
          if (!found) begin
            out_q.verdict <= ipfd_pkg::V_NOROUTE;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            gw <= rt_gw[best];
            port <= rt_port[best];
            ni <= '0;
            found <= 1'b0;
            state <= S_ARP;
          end
        end
        S_ARP: begin
          if (nb_use[ni[NW-1:0]] && cmp_eq) begin
            found <= 1'b1;
            out_q.dst_mac <= nb_mac[ni[NW-1:0]];
            state <= S_DONE;
          end else if (ni == (NW+1)'(NEIGHBOR_ENTRIES - 1)) begin
            state <= S_DONE;
          end else begin
            ni <= ni + 1'b1;
          end
        end
        S_DONE: begin
          if (found) begin
            out_q.verdict <= ipfd_pkg::V_FWD;
            out_q.egress_port <= port;
            out_q.src_mac <= ({30'd0, port} < PORTS) ? pmac[PW'(port)] : 48'd0;
            out_q.new_ttl <= ttl_q - 8'd1;
            out_q.new_checksum <= ~ipfd_pkg::fold_add(sum_q, {ttl_q - 8'd1, 8'd0});
          end else begin
            out_q <= '{verdict: ipfd_pkg::V_NOARP, default: '0};
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("ready while walking tables");
  a_no_walk_with_pending: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !out_valid) else $error("walk while verdict pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_q))
    else $error("verdict changed under stall");
  a_fwd_ttl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.verdict == ipfd_pkg::V_FWD |-> out_q.new_ttl != 8'd0)
    else $error("forward with zero ttl");
`endif

endmodule
